>>> design/hep_pkg.sv
// Shared types and constants for the hello extension parser.
package hep_pkg;

    // Result kinds
    localparam logic KIND_NAME   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_NO_PAIR   = 2'd2;

    // Config register indexes and reset values
    localparam logic       CFG_HASH_IDX   = 1'b0;
    localparam logic       CFG_SIG_IDX    = 1'b1;
    localparam logic [7:0] CFG_HASH_RESET = 8'd2;
    localparam logic [7:0] CFG_SIG_RESET  = 8'd1;

    // Result queue depth
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 3;

    typedef struct packed {
        logic       kind;
        logic [7:0] position;
        logic [7:0] value;
        logic [1:0] status;
        logic [7:0] name_len;
    } result_t;

    // Up to two results from one byte, in order
    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic [7:0] hash_code;
        logic [7:0] sig_code;
    } cfg_t;

endpackage

>>> design/hep_if.sv
// Stream interfaces for input bytes and result words.
interface hep_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface hep_result_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] name_position;
    logic [7:0] name_value;
    logic [1:0] parse_status;
    logic [7:0] accepted_name_length;

    modport source (output valid, result_kind, name_position, name_value, parse_status,
                    accepted_name_length, input ready);
    modport sink (input valid, result_kind, name_position, name_value, parse_status,
                  accepted_name_length, output ready);
endinterface

>>> design/hep_parser.sv
// Record parser: state update and result generation for one byte.
module hep_parser #(
    parameter logic [7:0] NAME_LIMIT = 8'd255
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        data,
    input  logic              last,
    input  hep_pkg::cfg_t     cfg,
    output hep_pkg::push_t    push
);

    typedef enum logic [15:0] {
        PH_TYPE_HI    = 16'h0001,
        PH_TYPE_LO    = 16'h0002,
        PH_LEN_HI     = 16'h0004,
        PH_LEN_LO     = 16'h0008,
        PH_SKIP       = 16'h0010,
        PH_SN_LIST_HI = 16'h0020,
        PH_SN_LIST_LO = 16'h0040,
        PH_SN_TYPE    = 16'h0080,
        PH_SN_NLEN_HI = 16'h0100,
        PH_SN_NLEN_LO = 16'h0200,
        PH_SN_NAME    = 16'h0400,
        PH_SA_LEN_HI  = 16'h0800,
        PH_SA_LEN_LO  = 16'h1000,
        PH_SA_HASH    = 16'h2000,
        PH_SA_SIG     = 16'h4000,
        PH_SN_TAIL    = 16'h8000
    } phase_t;

    localparam logic [15:0] TYPE_SERVER_NAME = 16'd0;
    localparam logic [15:0] TYPE_SIG_ALGS    = 16'd13;

    phase_t      phase_reg, phase_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] list_reg, list_next;
    logic [15:0] pending_reg, pending_next;
    logic [7:0]  counter_reg, counter_next;
    logic [7:0]  hash_reg, hash_next;
    logic [1:0]  err_reg, err_next;
    logic [7:0]  lastlen_reg, lastlen_next;

    logic [15:0]      rem_dec;
    logic [15:0]      rem_full;
    logic [15:0]      list_full;
    logic [15:0]      pend_full;
    logic [7:0]       cnt_inc;
    logic             is_hdr;
    hep_pkg::result_t stat;

    always_comb
    begin
        phase_next   = phase_reg;
        type_next    = type_reg;
        rem_next     = rem_reg;
        list_next    = list_reg;
        pending_next = pending_reg;
        counter_next = counter_reg;
        hash_next    = hash_reg;
        err_next     = err_reg;
        lastlen_next = lastlen_reg;
        push         = '0;
        stat         = '0;

        rem_dec   = rem_reg - 16'd1;
        rem_full  = {rem_reg[15:8], data};
        list_full = {list_reg[15:8], data};
        pend_full = {pending_reg[15:8], data};
        cnt_inc   = counter_reg + 8'd1;
        is_hdr    = (phase_reg == PH_TYPE_HI) || (phase_reg == PH_TYPE_LO)
                 || (phase_reg == PH_LEN_HI) || (phase_reg == PH_LEN_LO);

        if (err_reg == hep_pkg::ST_OK)
        begin
            if (is_hdr)
            begin
                unique case (phase_reg)
                    PH_TYPE_HI:
                    begin
                        type_next  = {data, 8'h00};
                        phase_next = PH_TYPE_LO;
                    end
                    PH_TYPE_LO:
                    begin
                        type_next  = {type_reg[15:8], data};
                        phase_next = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        rem_next   = {data, 8'h00};
                        phase_next = PH_LEN_LO;
                    end
                    default:
                    begin
                        rem_next = rem_full;
                        if ((type_reg == TYPE_SERVER_NAME || type_reg == TYPE_SIG_ALGS)
                            && rem_full < 16'd2)
                            err_next = hep_pkg::ST_MALFORMED;
                        else if (rem_full == 16'd0)
                            phase_next = PH_TYPE_HI;
                        else if (type_reg == TYPE_SERVER_NAME)
                            phase_next = PH_SN_LIST_HI;
                        else if (type_reg == TYPE_SIG_ALGS)
                            phase_next = PH_SA_LEN_HI;
                        else
                            phase_next = PH_SKIP;
                    end
                endcase
            end
            else
            begin
                rem_next = rem_dec;
                unique case (phase_reg)
                    PH_SN_LIST_HI:
                    begin
                        list_next  = {data, 8'h00};
                        phase_next = PH_SN_LIST_LO;
                    end
                    PH_SN_LIST_LO:
                    begin
                        list_next  = list_full;
                        phase_next = (list_full > rem_dec || list_full < 16'd3)
                                   ? PH_SKIP : PH_SN_TYPE;
                    end
                    PH_SN_TYPE:
                        phase_next = (data != 8'd0) ? PH_SKIP : PH_SN_NLEN_HI;
                    PH_SN_NLEN_HI:
                    begin
                        pending_next = {data, 8'h00};
                        phase_next   = PH_SN_NLEN_LO;
                    end
                    PH_SN_NLEN_LO:
                    begin
                        pending_next = pend_full;
                        if (({1'b0, pend_full} + 17'd3 > {1'b0, list_reg})
                            || pend_full > {8'h00, NAME_LIMIT})
                            phase_next = PH_SKIP;
                        else
                        begin
                            counter_next = 8'd0;
                            phase_next   = (pend_full == 16'd0) ? PH_SN_TAIL : PH_SN_NAME;
                        end
                    end
                    PH_SN_NAME:
                    begin
                        push.cnt            = 2'd1;
                        push.first.kind     = hep_pkg::KIND_NAME;
                        push.first.position = counter_reg;
                        push.first.value    = data;
                        counter_next        = cnt_inc;
                        if ({8'h00, cnt_inc} >= pending_reg)
                            phase_next = PH_SN_TAIL;
                    end
                    PH_SA_LEN_HI:
                    begin
                        list_next  = {data, 8'h00};
                        phase_next = PH_SA_LEN_LO;
                    end
                    PH_SA_LEN_LO:
                    begin
                        list_next  = list_full;
                        phase_next = (list_full > rem_dec || list_full[0] || rem_dec[0])
                                   ? PH_SKIP : PH_SA_HASH;
                    end
                    PH_SA_HASH:
                    begin
                        hash_next  = data;
                        phase_next = PH_SA_SIG;
                    end
                    PH_SA_SIG:
                        phase_next = (hash_reg == cfg.hash_code && data == cfg.sig_code)
                                   ? PH_SKIP : PH_SA_HASH;
                    default:
                    begin
                    end
                endcase
                // record end: commit name or flag an unfinished body
                if (rem_dec == 16'd0)
                begin
                    if (phase_next == PH_SN_TAIL)
                        lastlen_next = pending_next[7:0];
                    else if (phase_next == PH_SA_HASH)
                        err_next = hep_pkg::ST_NO_PAIR;
                    else if (phase_next != PH_SKIP)
                        err_next = hep_pkg::ST_MALFORMED;
                    phase_next = PH_TYPE_HI;
                end
            end
        end

        if (last)
        begin
            stat.kind     = hep_pkg::KIND_STATUS;
            stat.status   = (err_next == hep_pkg::ST_OK && phase_next != PH_TYPE_HI)
                          ? hep_pkg::ST_MALFORMED : err_next;
            stat.name_len = lastlen_next;
            if (push.cnt == 2'd0)
                push.first = stat;
            else
                push.second = stat;
            push.cnt = push.cnt + 2'd1;

            phase_next   = PH_TYPE_HI;
            type_next    = '0;
            rem_next     = '0;
            list_next    = '0;
            pending_next = '0;
            counter_next = '0;
            hash_next    = '0;
            err_next     = hep_pkg::ST_OK;
            lastlen_next = '0;
        end

        if (!fire)
            push.cnt = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TYPE_HI;
            type_reg    <= '0;
            rem_reg     <= '0;
            list_reg    <= '0;
            pending_reg <= '0;
            counter_reg <= '0;
            hash_reg    <= '0;
            err_reg     <= hep_pkg::ST_OK;
            lastlen_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            type_reg    <= type_next;
            rem_reg     <= rem_next;
            list_reg    <= list_next;
            pending_reg <= pending_next;
            counter_reg <= counter_next;
            hash_reg    <= hash_next;
            err_reg     <= err_next;
            lastlen_reg <= lastlen_next;
        end
    end

`ifndef SYNTH
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last |=> phase_reg == PH_TYPE_HI && err_reg == hep_pkg::ST_OK
                         && lastlen_reg == 8'd0)
        else $error("parser not rearmed after final byte");
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg == hep_pkg::ST_OK || err_reg == hep_pkg::ST_MALFORMED
        || err_reg == hep_pkg::ST_NO_PAIR)
        else $error("bad error code");
    a_no_name_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        fire && push.cnt != 2'd0 && push.first.kind == hep_pkg::KIND_NAME
        |-> err_reg == hep_pkg::ST_OK)
        else $error("name byte emitted after error");
`endif

endmodule

>>> design/hep_result_fifo.sv
// Small result queue: up to two words in, one word out per cycle.
module hep_result_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hep_pkg::push_t                 push,
    input  logic                           pop,
    output hep_pkg::result_t               head,
    output logic [hep_pkg::RES_CNT_W-1:0]  count
);

    hep_pkg::result_t                mem [hep_pkg::RES_DEPTH];
    logic [hep_pkg::RES_PTR_W-1:0]   rd_ptr_reg, wr_ptr_reg;
    logic [hep_pkg::RES_CNT_W-1:0]   count_reg;
    logic [hep_pkg::RES_PTR_W-1:0]   wr_ptr_inc;

    assign wr_ptr_inc = wr_ptr_reg + hep_pkg::RES_PTR_W'(1);

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.cnt == 2'd2)
            mem[wr_ptr_inc] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + hep_pkg::RES_PTR_W'(push.cnt);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + hep_pkg::RES_PTR_W'(1);
            count_reg <= count_reg + hep_pkg::RES_CNT_W'(push.cnt) - hep_pkg::RES_CNT_W'(pop);
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

>>> design/hello_extension_parser_unit.sv
// Top level of the hello extension parser: input register, parser, result queue.
// A result word reaches the output through the input register and then the result queue.
// Throughput: one byte per cycle while the queue has room; a final byte that also
//   carries a name byte makes two words; the 4-word queue drains one word per ready cycle.
// Input stalls only while the queue has fewer than two free slots.
// Reset clears parser state and the queue, and loads config to hash 2, signature 1.
module hello_extension_parser_unit #(
    parameter int NAME_CAPACITY = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    hep_byte_if.sink           ext_stream,
    hep_result_if.source       result_stream,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data
);

    // longest name the parser will accept
    localparam int          LIMIT_INT  = (NAME_CAPACITY - 1 > 255) ? 255 : NAME_CAPACITY - 1;
    localparam logic [7:0]  NAME_LIMIT = LIMIT_INT[7:0];

    // config registers
    logic [7:0]    hash_reg;
    logic [7:0]    sig_reg;
    hep_pkg::cfg_t cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= hep_pkg::CFG_HASH_RESET;
            sig_reg  <= hep_pkg::CFG_SIG_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == hep_pkg::CFG_HASH_IDX)
                hash_reg <= cfg_data;
            if (cfg_index == hep_pkg::CFG_SIG_IDX)
                sig_reg <= cfg_data;
        end
    end

    assign cfg.hash_code = hash_reg;
    assign cfg.sig_code  = sig_reg;

    // input register: holds one byte until the parser takes it
    logic       in_v_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       fire;
    logic       in_take;

    logic [hep_pkg::RES_CNT_W-1:0] q_count;
    hep_pkg::push_t                push;
    hep_pkg::result_t              head;
    logic                          pop;

    // parser steps when the queue can absorb the worst case of two words
    assign fire    = in_v_reg && (q_count <= hep_pkg::RES_CNT_W'(hep_pkg::RES_DEPTH - 2));
    assign ext_stream.ready = !in_v_reg || fire;
    assign in_take = ext_stream.valid && ext_stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (in_take)
            in_v_reg <= 1'b1;
        else if (fire)
            in_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= ext_stream.data_byte;
            in_last_reg <= ext_stream.last_byte;
        end
    end

    hep_parser #(
        .NAME_LIMIT (NAME_LIMIT)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .data  (in_data_reg),
        .last  (in_last_reg),
        .cfg   (cfg),
        .push  (push)
    );

    hep_result_fifo u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .count (q_count)
    );

    // output word straight from the queue head
    assign result_stream.valid                = (q_count != '0);
    assign result_stream.result_kind          = head.kind;
    assign result_stream.name_position        = head.position;
    assign result_stream.name_value           = head.value;
    assign result_stream.parse_status         = head.status;
    assign result_stream.accepted_name_length = head.name_len;
    assign pop = result_stream.valid && result_stream.ready;

endmodule

>>> sim/hep_tb_pkg.sv
// Extension type codes shared by the parser stimulus and its checker.
package hep_tb_pkg;

    localparam logic [15:0] EXT_SERVER_NAME = 16'd0;
    localparam logic [15:0] EXT_SIG_ALGS    = 16'd13;
    localparam logic [7:0]  SNI_HOST_NAME   = 8'd0;

endpackage

>>> sim/hep_parse_checker.sv
// Checker for the hello extension parser: predicts result words and compares them.
module hep_parse_checker #(
    parameter int NAME_CAPACITY = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       out_kind,
    input  logic [7:0] out_position,
    input  logic [7:0] out_value,
    input  logic [1:0] out_status,
    input  logic [7:0] out_name_len,
    output int         fail_count,
    output int         words_pending
);

    localparam int NAME_LIMIT = (NAME_CAPACITY - 1 > 255) ? 255 : NAME_CAPACITY - 1;

    typedef enum logic [3:0] {
        P_TYPE_HI, P_TYPE_LO, P_LEN_HI, P_LEN_LO, P_SKIP,
        P_SNI_LIST_HI, P_SNI_LIST_LO, P_SNI_NAME_TYPE, P_SNI_NLEN_HI, P_SNI_NLEN_LO,
        P_SNI_NAME, P_SIG_LEN_HI, P_SIG_LEN_LO, P_SIG_HASH, P_SIG_SIGN, P_SNI_DONE
    } parse_phase_t;

    parse_phase_t       phase;
    logic [15:0]        ext_type;
    logic [15:0]        ext_left;
    logic [15:0]        list_len;
    logic [15:0]        name_len_field;
    logic [7:0]         name_idx;
    logic [7:0]         held_hash;
    logic [7:0]         committed_len;
    logic [1:0]         status;
    hep_pkg::cfg_t      req;
    hep_pkg::result_t   expected_words[$];
    int                 n_fail = 0;

    function automatic string word_str(input hep_pkg::result_t w);
        return $sformatf("kind=%0d pos=%0d value=%02h status=%0d len=%0d",
                         w.kind, w.position, w.value, w.status, w.name_len);
    endfunction

    task automatic clear_parse();
        phase          = P_TYPE_HI;
        ext_type       = '0;
        ext_left       = '0;
        list_len       = '0;
        name_len_field = '0;
        name_idx       = '0;
        held_hash      = '0;
        status         = hep_pkg::ST_OK;
        committed_len  = '0;
    endtask

    task automatic push_word(input logic kind, input logic [7:0] pos, input logic [7:0] val,
                             input logic [1:0] st, input logic [7:0] len);
        hep_pkg::result_t w;
        w.kind     = kind;
        w.position = pos;
        w.value    = val;
        w.status   = st;
        w.name_len = len;
        expected_words.push_back(w);
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic fin);
        if (status == hep_pkg::ST_OK)
        begin
            case (phase)
                P_TYPE_HI:
                begin
                    ext_type = {b, 8'h00};
                    phase    = P_TYPE_LO;
                end
                P_TYPE_LO:
                begin
                    ext_type[7:0] = b;
                    phase         = P_LEN_HI;
                end
                P_LEN_HI:
                begin
                    ext_left = {b, 8'h00};
                    phase    = P_LEN_LO;
                end
                P_LEN_LO:
                begin
                    ext_left[7:0] = b;
                    if ((ext_type == hep_tb_pkg::EXT_SERVER_NAME
                         || ext_type == hep_tb_pkg::EXT_SIG_ALGS)
                        && ext_left < 16'd2)
                        status = hep_pkg::ST_MALFORMED;
                    else if (ext_left == 16'd0)
                        phase = P_TYPE_HI;
                    else if (ext_type == hep_tb_pkg::EXT_SERVER_NAME)
                        phase = P_SNI_LIST_HI;
                    else if (ext_type == hep_tb_pkg::EXT_SIG_ALGS)
                        phase = P_SIG_LEN_HI;
                    else
                        phase = P_SKIP;
                end
                default:
                begin
                    ext_left = ext_left - 16'd1;
                    case (phase)
                        P_SNI_LIST_HI:
                        begin
                            list_len = {b, 8'h00};
                            phase    = P_SNI_LIST_LO;
                        end
                        P_SNI_LIST_LO:
                        begin
                            list_len[7:0] = b;
                            phase = (list_len > ext_left || list_len < 16'd3) ?
                                    P_SKIP : P_SNI_NAME_TYPE;
                        end
                        P_SNI_NAME_TYPE:
                            phase = (b != hep_tb_pkg::SNI_HOST_NAME) ? P_SKIP : P_SNI_NLEN_HI;
                        P_SNI_NLEN_HI:
                        begin
                            name_len_field = {b, 8'h00};
                            phase          = P_SNI_NLEN_LO;
                        end
                        P_SNI_NLEN_LO:
                        begin
                            name_len_field[7:0] = b;
                            if (int'(name_len_field) + 3 > int'(list_len)
                                || int'(name_len_field) > NAME_LIMIT)
                                phase = P_SKIP;
                            else
                            begin
                                name_idx = '0;
                                phase = (name_len_field == 16'd0) ? P_SNI_DONE : P_SNI_NAME;
                            end
                        end
                        P_SNI_NAME:
                        begin
                            push_word(hep_pkg::KIND_NAME, name_idx, b, hep_pkg::ST_OK, 8'd0);
                            name_idx = name_idx + 8'd1;
                            if ({8'h00, name_idx} >= name_len_field)
                                phase = P_SNI_DONE;
                        end
                        P_SIG_LEN_HI:
                        begin
                            list_len = {b, 8'h00};
                            phase    = P_SIG_LEN_LO;
                        end
                        P_SIG_LEN_LO:
                        begin
                            list_len[7:0] = b;
                            phase = (list_len > ext_left || list_len[0] || ext_left[0]) ?
                                    P_SKIP : P_SIG_HASH;
                        end
                        P_SIG_HASH:
                        begin
                            held_hash = b;
                            phase     = P_SIG_SIGN;
                        end
                        P_SIG_SIGN:
                            phase = (held_hash == req.hash_code && b == req.sig_code) ?
                                    P_SKIP : P_SIG_HASH;
                        default: ;
                    endcase
                    // record boundary: commit the name or flag what is left open
                    if (ext_left == 16'd0)
                    begin
                        if (phase == P_SNI_DONE)
                            committed_len = name_len_field[7:0];
                        else if (phase == P_SIG_HASH)
                            status = hep_pkg::ST_NO_PAIR;
                        else if (phase != P_SKIP)
                            status = hep_pkg::ST_MALFORMED;
                        phase = P_TYPE_HI;
                    end
                end
            endcase
        end

        if (fin)
        begin
            if (status == hep_pkg::ST_OK && phase != P_TYPE_HI)
                status = hep_pkg::ST_MALFORMED;
            push_word(hep_pkg::KIND_STATUS, 8'd0, 8'd0, status, committed_len);
            clear_parse();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hep_pkg::result_t got;
        hep_pkg::result_t exp_w;
        if (!rst_n)
        begin
            clear_parse();
            req.hash_code = hep_pkg::CFG_HASH_RESET;
            req.sig_code  = hep_pkg::CFG_SIG_RESET;
            expected_words.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == hep_pkg::CFG_HASH_IDX)
                    req.hash_code = cfg_data;
                else
                    req.sig_code = cfg_data;
            end
            // a word leaving now was caused by an earlier byte, via the input register and the queue
            if (out_valid && out_ready)
            begin
                got = {out_kind, out_position, out_value, out_status, out_name_len};
                if (expected_words.size() == 0)
                begin
                    n_fail++;
                    $display("%0t: unexpected word, expected none, actual %s",
                             $time, word_str(got));
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (got !== exp_w)
                    begin
                        n_fail++;
                        $display("%0t: word mismatch, expected %s, actual %s",
                                 $time, word_str(exp_w), word_str(got));
                    end
                end
            end
            if (in_valid && in_ready)
                predict_byte(in_byte, in_last);
        end
        fail_count    <= n_fail;
        words_pending <= expected_words.size();
    end

endmodule

>>> sim/tb_hello_extension_parser_unit.sv
// Testbench top for the hello extension parser: stimulus, flow control and verdict.
module tb_hello_extension_parser_unit;

    localparam int NAME_CAPACITY = 256;
    localparam int ITEM_TARGET   = 1800;   // bytes to push through, directed part included
    localparam int CFG_PHASES    = 6;      // register settings visited in the random part
    localparam int LONG_HOLD     = 400;    // cycles the result side stays blocked
    localparam int DRAIN_CYCLES  = 8;      // input register, then queue; leave margin
    localparam int TIMEOUT       = 10_000_000;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;

    hep_byte_if   ext_if();
    hep_result_if res_if();

    int fail_count;
    int words_pending;

    // stimulus bookkeeping
    logic [7:0] blk[$];        // bytes of the extensions block being built
    int         items_sent;
    logic [7:0] req_hash;      // current register values, so blocks can hit the pair
    logic [7:0] req_sig;
    bit         no_idle   = 1'b0;
    bit         hold_long = 1'b0;

    hello_extension_parser_unit #(
        .NAME_CAPACITY (NAME_CAPACITY)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .ext_stream    (ext_if),
        .result_stream (res_if),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    hep_parse_checker #(
        .NAME_CAPACITY (NAME_CAPACITY)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (ext_if.valid),
        .in_ready      (ext_if.ready),
        .in_byte       (ext_if.data_byte),
        .in_last       (ext_if.last_byte),
        .out_valid     (res_if.valid),
        .out_ready     (res_if.ready),
        .out_kind      (res_if.result_kind),
        .out_position  (res_if.name_position),
        .out_value     (res_if.name_value),
        .out_status    (res_if.parse_status),
        .out_name_len  (res_if.accepted_name_length),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    always #5 clk = ~clk;

    // Big-endian 16-bit field, as every header and length in the block is.
    task automatic push_u16(input logic [15:0] v);
        blk.push_back(v[15:8]);
        blk.push_back(v[7:0]);
    endtask

    // Drive the queued block one word per handshake, last_byte on the final one.
    // Random gaps land before any byte, so they hit every parser phase.
    task automatic send_block();
        for (int i = 0; i < blk.size(); i++)
        begin
            if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                ext_if.valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            ext_if.valid     <= 1'b1;
            ext_if.data_byte <= blk[i];
            ext_if.last_byte <= (i == blk.size() - 1);
            @(posedge clk);
            while (!ext_if.ready) @(posedge clk);
            items_sent++;
        end
        blk.delete();
    endtask

    // Stop offering words and wait until every predicted word has come back.
    // The extra cycles cover trailing bytes that produce nothing but are still
    // in flight when the last word arrives.
    task automatic wait_drained();
        ext_if.valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both pair registers; only called while the parser is idle.
    task automatic program_regs(input logic [7:0] hash, input logic [7:0] sig);
        cfg_we    <= 1'b1;
        cfg_index <= hep_pkg::CFG_HASH_IDX;
        cfg_data  <= hash;
        @(posedge clk);
        cfg_index <= hep_pkg::CFG_SIG_IDX;
        cfg_data  <= sig;
        @(posedge clk);
        cfg_we   <= 1'b0;
        req_hash = hash;
        req_sig  = sig;
    endtask

    // Build one random extensions block. Mostly well-formed records with random
    // content so the parser gets deep into the server-name and sig-alg paths;
    // a minority carries broken fields, short records, noise or a cut-off tail.
    task automatic build_random_block();
        int          roll;
        int          flaw;
        int          nlen;
        int          list_extra;
        int          rec_extra;
        int          npairs;
        int          hit;
        int          extra;
        int          odd_pad;
        int          cut;
        logic [15:0] list_field;
        logic [15:0] nlen_field;
        logic [15:0] etype;
        logic [7:0]  ntype;
        logic [7:0]  h;

        repeat ($urandom_range(1, 4))
        begin
            roll = $urandom_range(0, 99);
            flaw = $urandom_range(0, 19);
            if (roll < 35)
            begin
                // server name: list length, name type, name length, name bytes
                nlen = $urandom_range(0, 12);
                if ($urandom_range(0, 99) == 0)
                    nlen = 255;                     // largest name that fits
                else if ($urandom_range(0, 99) == 0)
                    nlen = 256;                     // one past the capacity limit
                list_extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
                rec_extra  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
                list_field = 16'(3 + nlen + list_extra);
                nlen_field = 16'(nlen);
                ntype      = hep_tb_pkg::SNI_HOST_NAME;
                case (flaw)
                    0: list_field = 16'($urandom_range(0, 2));      // list too short
                    1: list_field = 16'(3 + nlen + list_extra + rec_extra
                                        + $urandom_range(1, 3));    // list overruns record
                    2: ntype = 8'($urandom_range(1, 255));          // not a host name
                    3: nlen_field = 16'(nlen + list_extra + 1);     // name overruns list
                    default: ;
                endcase
                push_u16(hep_tb_pkg::EXT_SERVER_NAME);
                push_u16(16'(5 + nlen + list_extra + rec_extra));
                push_u16(list_field);
                blk.push_back(ntype);
                push_u16(nlen_field);
                repeat (nlen + list_extra + rec_extra) blk.push_back(8'($urandom));
            end
            else if (roll < 65)
            begin
                // signature algorithms: pair list, often holding the wanted pair
                npairs  = $urandom_range(0, 6);
                hit     = (npairs > 0 && $urandom_range(0, 9) < 6) ?
                          $urandom_range(0, npairs - 1) : -1;
                extra   = ($urandom_range(0, 5) == 0) ? 2 * $urandom_range(1, 2) : 0;
                odd_pad = 0;
                list_field = 16'(2 * npairs);
                case (flaw)
                    0: list_field = 16'(2 * npairs + 1);            // odd list length
                    1: list_field = 16'(2 * npairs + extra + 2);    // list overruns record
                    2: odd_pad = 1;                                 // odd record body
                    default: ;
                endcase
                push_u16(hep_tb_pkg::EXT_SIG_ALGS);
                push_u16(16'(2 + 2 * npairs + extra + odd_pad));
                push_u16(list_field);
                for (int k = 0; k < npairs; k++)
                begin
                    if (k == hit)
                    begin
                        blk.push_back(req_hash);
                        blk.push_back(req_sig);
                    end
                    else
                    begin
                        // other pairs: a random signature, with the right hash in about a third of them
                        h = ($urandom_range(0, 2) == 0) ? req_hash : 8'($urandom);
                        blk.push_back(h);
                        blk.push_back(8'($urandom));
                    end
                end
                repeat (extra + odd_pad) blk.push_back(8'($urandom));
            end
            else if (roll < 85)
            begin
                // some other extension, skipped whole
                etype = 16'($urandom_range(0, 65535));
                if (etype == hep_tb_pkg::EXT_SERVER_NAME || etype == hep_tb_pkg::EXT_SIG_ALGS)
                    etype = etype + 16'd1;
                nlen = $urandom_range(0, 6);
                push_u16(etype);
                push_u16(16'(nlen));
                repeat (nlen) blk.push_back(8'($urandom));
            end
            else if (roll < 90)
            begin
                // server name or sig-alg record too short to hold its own list length
                nlen = $urandom_range(0, 1);
                push_u16(($urandom_range(0, 1) == 0) ? hep_tb_pkg::EXT_SERVER_NAME
                                                     : hep_tb_pkg::EXT_SIG_ALGS);
                push_u16(16'(nlen));
                repeat (nlen) blk.push_back(8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 8)) blk.push_back(8'($urandom));
            end
        end

        // now and then the block ends in the middle of a header or a record
        if ($urandom_range(0, 9) == 0 && blk.size() > 1)
        begin
            cut = $urandom_range(1, blk.size() - 1);
            while (blk.size() > cut) void'(blk.pop_back());
        end
    endtask

    // Result side: ready runs and stall bursts, one long hold-off on request,
    // and always ready once the final quiet stretch begins.
    initial
    begin
        res_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_long)
            begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_long = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 2) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    initial
    begin
        ext_if.valid     <= 1'b0;
        ext_if.data_byte <= 8'h00;
        ext_if.last_byte <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= hep_pkg::CFG_HASH_IDX;
        cfg_data         <= 8'h00;
        req_hash   = hep_pkg::CFG_HASH_RESET;
        req_sig    = hep_pkg::CFG_SIG_RESET;
        items_sent = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed blocks, registers at their reset values.
        // Server-name record of length one: short record, malformed.
        push_u16(hep_tb_pkg::EXT_SERVER_NAME);
        push_u16(16'd1);
        send_block();
        // One-byte host name whose only byte also ends the block: a name word
        // and the status word from the same input word.
        push_u16(hep_tb_pkg::EXT_SERVER_NAME);
        push_u16(16'd6);
        push_u16(16'd4);
        blk.push_back(hep_tb_pkg::SNI_HOST_NAME);
        push_u16(16'd1);
        blk.push_back(8'hFF);
        send_block();
        // Sig-alg record with an empty pair list: pair missing.
        push_u16(hep_tb_pkg::EXT_SIG_ALGS);
        push_u16(16'd2);
        push_u16(16'd0);
        send_block();
        // Block of a single byte: header cut short.
        blk.push_back(8'h00);
        send_block();
        // Unknown type with zero length: clean, no name.
        push_u16(16'hFFFF);
        push_u16(16'd0);
        send_block();

        // Random part, one register setting per phase. Each phase starts with
        // the parser drained, which also gives the pause-until-empty case.
        for (int p = 0; p < CFG_PHASES; p++)
        begin
            wait_drained();
            case (p)
                0: program_regs(8'h00, 8'h00);
                1: program_regs(8'hFF, 8'hFF);
                2: program_regs(hep_pkg::CFG_HASH_RESET, hep_pkg::CFG_SIG_RESET);
                default: program_regs(8'($urandom), 8'($urandom));
            endcase
            // block the result side for a long stretch while bytes keep coming,
            // so the output queue fills and input ready drops
            if (p == 1 || p == 4)
                hold_long = 1'b1;
            if (p == CFG_PHASES - 1)
                no_idle = 1'b1;
            while (items_sent < (p + 1) * ITEM_TARGET / CFG_PHASES)
            begin
                build_random_block();
                send_block();
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: a hung handshake or words that never arrive end here.
    initial
    begin
        #TIMEOUT;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
design/hep_pkg.sv
design/hep_if.sv
design/hep_parser.sv
design/hep_result_fifo.sv
design/hello_extension_parser_unit.sv
sim/hep_tb_pkg.sv
sim/hep_parse_checker.sv
sim/tb_hello_extension_parser_unit.sv
